### design/pmurf_pkg.sv
package pmurf_pkg;

	localparam int REG_COUNT  = 256;
	localparam int ADDR_W     = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [6:0] DEV_ADDR = 7'h34;

	// opcodes
	localparam logic [2:0] OP_SET_PTR = 3'd0;
	localparam logic [2:0] OP_WRITE   = 3'd1;
	localparam logic [2:0] OP_READ    = 3'd2;
	localparam logic [2:0] OP_IRQ     = 3'd3;
	localparam logic [2:0] OP_RESET   = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BAT_PRESENT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUS_PRESENT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BAT_MV      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BUS_MV      = 8'd3;

	localparam logic [15:0] BAT_MV_RESET = 16'd3970;
	localparam logic [15:0] BUS_MV_RESET = 16'd5000;

	// register addresses
	localparam logic [7:0] A_POWER_STATUS  = 8'h00;
	localparam logic [7:0] A_CHARGE_STATUS = 8'h01;
	localparam logic [7:0] A_ID            = 8'h03;
	localparam logic [7:0] A_IRQ_FIRST     = 8'h44;
	localparam logic [7:0] A_IRQ_LAST      = 8'h47;
	localparam logic [7:0] A_IRQ_EXTRA     = 8'h4D;
	localparam logic [7:0] A_RO_FIRST      = 8'h56;
	localparam logic [7:0] A_RO_LAST       = 8'h7F;
	localparam logic [7:0] A_BUS_ADC       = 8'h5A;
	localparam logic [7:0] A_TEMP_ADC      = 8'h5E;
	localparam logic [7:0] A_BAT_ADC       = 8'h78;
	localparam logic [7:0] A_SYS_ADC       = 8'h7E;

	localparam logic [7:0] BUS_BITS  = 8'h24;
	localparam logic [7:0] BAT_BITS  = 8'h20;

	localparam logic [11:0] ADC_MAX  = 12'hFFF;
	localparam int          SYS_MV   = 3300;
	localparam logic [11:0] SYS_ADC  = 12'(SYS_MV * 10 / 14);
	localparam logic [11:0] TEMP_ADC = 12'd1697;

	// mv*10/11 and mv*10/17 by reciprocal multiply; inputs at or above the
	// limits saturate, so the product operand stays within 13 bits of mv
	localparam logic [15:0] BAT_SAT_MV = 16'd4506;
	localparam logic [15:0] BUS_SAT_MV = 16'd6964;
	localparam logic [15:0] RECIP_11   = 16'd47663;	// ceil(2^19 / 11)
	localparam logic [15:0] RECIP_17   = 16'd61681;	// ceil(2^20 / 17)

	// interrupt raise walks five registers
	localparam logic [2:0] IRQ_LAST = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_MODIFY = 4'b0010,
		ST_IRQ    = 4'b0100,
		ST_RESP   = 4'b1000
	} state_t;

	typedef struct packed {
		logic [7:0]  power_status;
		logic [7:0]  charge_status;
		logic [11:0] bat_adc;
		logic [11:0] bus_adc;
	} deriv_t;

	function automatic logic [11:0] adc_battery(input logic [15:0] mv);
		logic [15:0] x;
		logic [31:0] p;
		x = 16'(mv[12:0]) * 16'd10;
		p = 32'(x) * 32'(RECIP_11);
		return (mv >= BAT_SAT_MV) ? ADC_MAX : p[30:19];
	endfunction

	function automatic logic [11:0] adc_bus(input logic [15:0] mv);
		logic [16:0] x;
		logic [32:0] p;
		x = 17'(mv[12:0]) * 17'd10;
		p = 33'(x) * 33'(RECIP_17);
		return (mv >= BUS_SAT_MV) ? ADC_MAX : p[31:20];
	endfunction

	function automatic logic is_irq_reg(input logic [7:0] a);
		return (a >= A_IRQ_FIRST && a <= A_IRQ_LAST) || a == A_IRQ_EXTRA;
	endfunction

	function automatic logic is_read_only(input logic [7:0] a);
		return a <= A_ID || (a >= A_RO_FIRST && a <= A_RO_LAST);
	endfunction

	function automatic logic [7:0] irq_addr(input logic [2:0] idx);
		return (idx == IRQ_LAST) ? A_IRQ_EXTRA : A_IRQ_FIRST + 8'(idx);
	endfunction

	// power-on value of a writable register
	function automatic logic [7:0] reset_value(input logic [7:0] a);
		logic [7:0] v;
		unique case (a)
			8'h12:   v = 8'h03;
			8'h23:   v = 8'h16;
			8'h26:   v = 8'h68;
			8'h27:   v = 8'h68;
			8'h28:   v = 8'hFF;
			8'h31:   v = 8'h03;
			8'h33:   v = 8'hC0;
			8'h36:   v = 8'h0C;
			8'h82:   v = 8'hFF;
			8'h83:   v = 8'h80;
			8'h84:   v = 8'h32;
			8'h90:   v = 8'h07;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// contents of a read-only register; readings are high byte then low nibble
	function automatic logic [7:0] derived_value(input logic [7:0] a, input deriv_t d);
		logic [7:0] v;
		unique case (a)
			A_POWER_STATUS:   v = d.power_status;
			A_CHARGE_STATUS:  v = d.charge_status;
			A_ID:             v = 8'h03;
			A_BUS_ADC:        v = d.bus_adc[11:4];
			A_BUS_ADC + 8'd1: v = {4'h0, d.bus_adc[3:0]};
			A_TEMP_ADC:       v = TEMP_ADC[11:4];
			A_TEMP_ADC + 8'd1: v = {4'h0, TEMP_ADC[3:0]};
			A_BAT_ADC:        v = d.bat_adc[11:4];
			A_BAT_ADC + 8'd1: v = {4'h0, d.bat_adc[3:0]};
			A_SYS_ADC:        v = SYS_ADC[11:4];
			A_SYS_ADC + 8'd1: v = {4'h0, SYS_ADC[3:0]};
			default:          v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

### design/pmurf_cfg.sv
module pmurf_cfg
	import pmurf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output deriv_t                deriv
);

	logic        bat_present_q;
	logic        bus_present_q;
	logic [15:0] bat_mv_q;
	logic [15:0] bus_mv_q;
	deriv_t      deriv_q;

	assign cfg_ready = 1'b1;

	// out-of-range indexes fall through and are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bat_present_q <= 1'b1;
			bus_present_q <= 1'b1;
			bat_mv_q      <= BAT_MV_RESET;
			bus_mv_q      <= BUS_MV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BAT_PRESENT: bat_present_q <= cfg_data[0];
				CFG_BUS_PRESENT: bus_present_q <= cfg_data[0];
				CFG_BAT_MV:      bat_mv_q      <= cfg_data;
				CFG_BUS_MV:      bus_mv_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// refresh the derived view, registered from the settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deriv_q.power_status  <= BUS_BITS;
			deriv_q.charge_status <= BAT_BITS;
			deriv_q.bat_adc       <= adc_battery(BAT_MV_RESET);
			deriv_q.bus_adc       <= adc_bus(BUS_MV_RESET);
		end else begin
			deriv_q.power_status  <= bus_present_q ? BUS_BITS : 8'h00;
			deriv_q.charge_status <= bat_present_q ? BAT_BITS : 8'h00;
			deriv_q.bat_adc       <= adc_battery(bat_mv_q);
			deriv_q.bus_adc       <= adc_bus(bus_mv_q);
		end
	end

	assign deriv = deriv_q;

endmodule

### design/pmu_register_file_model.sv
// Register file of a power-management device seen from its two-wire bus.
//
// Input channel s_axis_*: one byte operation per transfer. tuser carries the
// opcode (set pointer, write, read, raise interrupts, reset); tdata carries
// device address, data byte and 40 interrupt flag bits. Output channel
// m_axis_*: exactly one result per operation, read byte in tdata and the
// "address not served" flag in tuser. Configuration channel cfg_*: index and
// 16-bit data, always ready; write only while no operation is in flight.
//
// Steps: pointer, write, read, reset and unserved accesses go from idle straight
// to the response state; a write to an interrupt status register first passes
// a modify step (read-modify-write); an interrupt raise walks five registers
// one at a time through the register memory, whose read port is registered.
// One operation is in flight at a time; a new one is taken as soon as the
// previous result sits in the output register, even if not yet taken.
//
// Reset (the pin or the reset opcode) clears the entry-valid flags, so every
// register reads its power-on value at once; the pointer returns to zero.
// A stalled receiver holds the result; a finished operation then waits in its
// response state and the input channel stays closed until the slot frees.
module pmu_register_file_model
	import pmurf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [6:0] device_address, [14:7] data_byte, [54:15] irq_flags, [55] zero
	input  logic [55:0]           s_axis_tdata,
	// [2:0] opcode
	input  logic [2:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] read_byte
	output logic [7:0]            m_axis_tdata,
	// [0] status_code
	output logic                  m_axis_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	deriv_t deriv;

	pmurf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.deriv     (deriv)
	);

	// input fields
	logic [2:0]       in_op;
	logic [6:0]       in_dev;
	logic [7:0]       in_data;
	logic [4:0][7:0]  in_flags;

	assign in_op    = s_axis_tuser;
	assign in_dev   = s_axis_tdata[6:0];
	assign in_data  = s_axis_tdata[14:7];
	assign in_flags = s_axis_tdata[54:15];

	state_t          state_q, state_d;
	logic [7:0]      ptr_q;
	logic [2:0]      op_q;
	logic [7:0]      data_q;
	logic [4:0][7:0] flags_q;
	logic            unserved_q;
	logic [2:0]      irq_idx_q, irq_idx_d;

	logic            s_accept;
	logic            unserved;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign unserved      = (in_op <= OP_READ) && (in_dev != DEV_ADDR);

	// register memory; entries never written since reset read as power-on values
	logic [7:0]          mem [REG_COUNT];
	logic [REG_COUNT-1:0] valid_q;
	logic                mem_we, mem_re;
	logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
	logic [7:0]          mem_wdata;
	logic [7:0]          rdata_q;
	logic                rvalid_q;
	logic [ADDR_W-1:0]   raddr_q;
	logic [7:0]          cur;

	// interrupt registers power up as zero
	assign cur = rvalid_q ? rdata_q : 8'h00;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q  <= mem[mem_raddr];
			rvalid_q <= valid_q[mem_raddr];
			raddr_q  <= mem_raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (s_accept && in_op == OP_RESET) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[mem_waddr] <= 1'b1;
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		irq_idx_d = irq_idx_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = ptr_q;
		mem_raddr = ptr_q;
		mem_wdata = in_data;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					state_d = ST_RESP;
					if (!unserved) begin
						unique case (in_op)
							OP_WRITE: begin
								if (is_irq_reg(ptr_q)) begin
									mem_re  = 1'b1;
									state_d = ST_MODIFY;
								end else if (!is_read_only(ptr_q)) begin
									mem_we = 1'b1;
								end
							end
							OP_READ: mem_re = 1'b1;
							OP_IRQ: begin
								mem_re    = 1'b1;
								mem_raddr = irq_addr(3'd0);
								irq_idx_d = 3'd0;
								state_d   = ST_IRQ;
							end
							default: ;
						endcase
					end
				end
			end
			ST_MODIFY: begin
				// write-one-to-clear
				mem_we    = 1'b1;
				mem_waddr = raddr_q;
				mem_wdata = cur & ~data_q;
				state_d   = ST_RESP;
			end
			ST_IRQ: begin
				// write back this register and fetch the next in the same cycle
				mem_we    = 1'b1;
				mem_waddr = irq_addr(irq_idx_q);
				mem_wdata = cur | flags_q[irq_idx_q];
				if (irq_idx_q == IRQ_LAST) begin
					state_d = ST_RESP;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = irq_addr(irq_idx_q + 3'd1);
					irq_idx_d = irq_idx_q + 3'd1;
				end
			end
			ST_RESP: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			irq_idx_q <= '0;
			ptr_q     <= '0;
		end else begin
			state_q   <= state_d;
			irq_idx_q <= irq_idx_d;
			if (s_accept && !unserved) begin
				unique case (in_op)
					OP_SET_PTR:        ptr_q <= in_data;
					OP_WRITE, OP_READ: ptr_q <= ptr_q + 8'd1;
					OP_RESET:          ptr_q <= '0;
					default: ;
				endcase
			end
		end
	end

	// hold the operation for the later steps
	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_q       <= in_op;
			data_q     <= in_data;
			flags_q    <= in_flags;
			unserved_q <= unserved;
		end
	end

	// read data: read-only registers come from the derived view
	logic [7:0] read_value;
	logic       load;

	assign read_value = is_read_only(raddr_q) ? derived_value(raddr_q, deriv) :
	                    rvalid_q ? rdata_q : reset_value(raddr_q);
	assign load = (state_q == ST_RESP) && (!m_axis_tvalid || m_axis_tready);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= (op_q == OP_READ && !unserved_q) ? read_value : 8'h00;
			out_status_q <= unserved_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = out_status_q;

	// a taken operation always leaves idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> state_q != ST_IDLE)
		else $error("operation taken but sequencer stayed idle");

	// read-only registers are never written into the memory
	a_no_ro_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !is_read_only(mem_waddr))
		else $error("memory write to a read-only register");

	// the pointer moves only on an input transfer
	a_ptr_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!s_accept |=> $stable(ptr_q))
		else $error("pointer moved without an input transfer");

	// interrupt walk stays within its five registers
	a_irq_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IRQ |-> irq_idx_q <= IRQ_LAST)
		else $error("interrupt walk index out of range");

	// a result appears only from the response step
	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_RESP))
		else $error("result raised outside the response step");

endmodule

### test/pmu_register_file_model_tb.sv
`timescale 1ns / 1ps

// Checks the power-management register file through its stream ports.
// A local image of the register store, pointer and configuration is updated
// on every accepted transfer, and the reply it gives is queued; every reply
// the block emits is compared field by field with the oldest queued one.
module pmu_register_file_model_tb;
	import pmurf_pkg::*;

	// spare opcodes that the block must treat as no-ops
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
	// an index past the last configuration register
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_OF_RANGE = 8'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX    = 8'd255;

	localparam int CYCLE_LIMIT   = 200000;
	// longest operation (interrupt raise) plus margin
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS  = 1000;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       status_code;
	} reply_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [55:0]           s_axis_tdata = '0;
	logic [2:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// local image of the device
	logic [7:0]  reg_image [0:255];
	logic [7:0]  image_ptr;
	logic        img_bat_present;
	logic        img_bus_present;
	logic [15:0] img_bat_mv;
	logic [15:0] img_bus_mv;

	reply_t pending_replies [$];
	int     error_count = 0;
	int     cycle_count = 0;
	// while set, neither side inserts idle cycles
	logic   quiet_stretch = 1'b0;

	pmu_register_file_model u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Register image
	// ------------------------------------------------------------------

	// store a 12-bit reading as high byte then low nibble, saturating
	function automatic void put_reading(input logic [7:0] addr, input int unsigned raw);
		logic [11:0] code;
		code = (raw > 32'hFFF) ? 12'hFFF : raw[11:0];
		reg_image[addr]        = code[11:4];
		reg_image[addr + 8'd1] = {4'h0, code[3:0]};
	endfunction

	// refresh status bits and ADC readings from the configuration
	function automatic void refresh_derived();
		reg_image[A_POWER_STATUS]  = (reg_image[A_POWER_STATUS] & ~8'h24) |
			(img_bus_present ? 8'h24 : 8'h00);
		reg_image[A_CHARGE_STATUS] = (reg_image[A_CHARGE_STATUS] & ~8'h20) |
			(img_bat_present ? 8'h20 : 8'h00);
		put_reading(A_BAT_ADC, 32'(img_bat_mv) * 10 / 11);
		put_reading(A_BUS_ADC, 32'(img_bus_mv) * 10 / 17);
		put_reading(A_SYS_ADC, 3300 * 10 / 14);
		put_reading(A_TEMP_ADC, 1697);
	endfunction

	function automatic void restore_image();
		for (int a = 0; a < 256; a++)
			reg_image[a] = 8'h00;
		image_ptr        = 8'h00;
		reg_image[8'h03] = 8'h03;
		reg_image[8'h12] = 8'h03;
		reg_image[8'h23] = 8'h16;
		reg_image[8'h26] = 8'h68;
		reg_image[8'h27] = 8'h68;
		reg_image[8'h28] = 8'hFF;
		reg_image[8'h31] = 8'h03;
		reg_image[8'h33] = 8'hC0;
		reg_image[8'h36] = 8'h0C;
		reg_image[8'h82] = 8'hFF;
		reg_image[8'h83] = 8'h80;
		reg_image[8'h84] = 8'h32;
		reg_image[8'h90] = 8'h07;
		refresh_derived();
	endfunction

	function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
			input logic [15:0] value);
		case (idx)
			CFG_BAT_PRESENT: img_bat_present = value[0];
			CFG_BUS_PRESENT: img_bus_present = value[0];
			CFG_BAT_MV:      img_bat_mv      = value;
			CFG_BUS_MV:      img_bus_mv      = value;
			default:         return;
		endcase
		refresh_derived();
	endfunction

	// advance the image by one operation and give the reply it causes
	function automatic reply_t predict_reply(input logic [2:0] op, input logic [6:0] dev,
			input logic [7:0] data, input logic [39:0] flags);
		reply_t r;
		logic [7:0] a;
		r = '0;
		a = image_ptr;
		if (op <= OP_READ && dev != DEV_ADDR) begin
			r.status_code = 1'b1;
		end else begin
			case (op)
				OP_SET_PTR: image_ptr = data;
				OP_WRITE: begin
					// interrupt status clears on ones; read-only ranges drop the data
					if ((a >= A_IRQ_FIRST && a <= A_IRQ_LAST) || a == A_IRQ_EXTRA)
						reg_image[a] = reg_image[a] & ~data;
					else if (!(a <= A_ID || (a >= A_RO_FIRST && a <= A_RO_LAST)))
						reg_image[a] = data;
					image_ptr = image_ptr + 8'd1;
				end
				OP_READ: begin
					r.read_byte = reg_image[a];
					image_ptr   = image_ptr + 8'd1;
				end
				OP_IRQ: begin
					for (int b = 0; b < 4; b++)
						reg_image[A_IRQ_FIRST + 8'(b)] = reg_image[A_IRQ_FIRST + 8'(b)] |
							flags[b*8 +: 8];
					reg_image[A_IRQ_EXTRA] = reg_image[A_IRQ_EXTRA] | flags[39:32];
				end
				OP_RESET: restore_image();
				default: ;
			endcase
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Reply checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		$display("MISMATCH cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// receiver stalls at random, except during the quiet stretch
	always @(posedge clk)
		m_axis_tready <= quiet_stretch || ($urandom_range(0, 99) >= 9);

	always @(posedge clk) begin : check_reply
		reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("reply with no operation outstanding");
			end else begin
				want = pending_replies.pop_front();
				if (m_axis_tdata !== want.read_byte)
					report_mismatch($sformatf("read_byte got %02h want %02h",
						m_axis_tdata, want.read_byte));
				if (m_axis_tuser !== want.status_code)
					report_mismatch($sformatf("status_code got %0b want %0b",
						m_axis_tuser, want.status_code));
			end
		end
	end

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offer one operation; tvalid is left high after the transfer so that
	// back-to-back items need no second assignment in the same step.
	task automatic send_op(input logic [2:0] op, input logic [6:0] dev,
			input logic [7:0] data, input logic [39:0] flags);
		while (!quiet_stretch && $urandom_range(0, 99) < 9) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {1'b0, flags, data, dev};
		do @(posedge clk); while (!s_axis_tready);
		pending_replies.push_back(predict_reply(op, dev, data, flags));
	endtask

	// drop tvalid, drain every outstanding reply, then let the block settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		apply_config(idx, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic bat, input logic bus,
			input logic [15:0] bat_mv, input logic [15:0] bus_mv);
		wait_idle();
		write_config(CFG_BAT_PRESENT, {15'h7FFF, bat});
		write_config(CFG_BUS_PRESENT, {15'h0000, bus});
		write_config(CFG_BAT_MV, bat_mv);
		write_config(CFG_BUS_MV, bus_mv);
	endtask

	// read back status bits and the two configured readings
	task automatic read_derived();
		send_op(OP_SET_PTR, DEV_ADDR, A_POWER_STATUS, '0);
		send_op(OP_READ, DEV_ADDR, '0, '0);
		send_op(OP_READ, DEV_ADDR, '0, '0);
		send_op(OP_SET_PTR, DEV_ADDR, A_BUS_ADC, '0);
		send_op(OP_READ, DEV_ADDR, '0, '0);
		send_op(OP_READ, DEV_ADDR, '0, '0);
		send_op(OP_SET_PTR, DEV_ADDR, A_BAT_ADC, '0);
		send_op(OP_READ, DEV_ADDR, '0, '0);
		send_op(OP_READ, DEV_ADDR, '0, '0);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// one of each operation and each corner of the register map
	task automatic test_directed_ops();
		// pointer wraps from the top register to zero
		send_op(OP_SET_PTR, DEV_ADDR, 8'hFE, '0);
		send_op(OP_READ, DEV_ADDR, '0, '0);
		send_op(OP_READ, DEV_ADDR, '0, '0);
		send_op(OP_READ, DEV_ADDR, '0, '0);
		// write to a read-only register is dropped, pointer still moves
		send_op(OP_SET_PTR, DEV_ADDR, A_POWER_STATUS, '0);
		send_op(OP_WRITE, DEV_ADDR, 8'hFF, '0);
		send_op(OP_READ, DEV_ADDR, '0, '0);
		// raise every flag from a foreign address, then clear by writing ones
		send_op(OP_IRQ, 7'h00, '0, 40'hFF_FFFF_FFFF);
		send_op(OP_SET_PTR, DEV_ADDR, A_IRQ_FIRST, '0);
		send_op(OP_WRITE, DEV_ADDR, 8'hA5, '0);
		send_op(OP_SET_PTR, DEV_ADDR, A_IRQ_FIRST, '0);
		send_op(OP_READ, DEV_ADDR, '0, '0);
		send_op(OP_SET_PTR, DEV_ADDR, A_IRQ_EXTRA, '0);
		send_op(OP_WRITE, DEV_ADDR, 8'hFF, '0);
		send_op(OP_SET_PTR, DEV_ADDR, A_IRQ_EXTRA, '0);
		send_op(OP_READ, DEV_ADDR, '0, '0);
		// edge of the upper read-only range
		send_op(OP_SET_PTR, DEV_ADDR, A_RO_LAST, '0);
		send_op(OP_WRITE, DEV_ADDR, 8'h5A, '0);
		send_op(OP_WRITE, DEV_ADDR, 8'hFF, '0);
		send_op(OP_SET_PTR, DEV_ADDR, A_RO_LAST, '0);
		send_op(OP_READ, DEV_ADDR, '0, '0);
		send_op(OP_READ, DEV_ADDR, '0, '0);
		// unserved device address on the bus operations
		send_op(OP_SET_PTR, 7'h00, 8'h44, '0);
		send_op(OP_WRITE, 7'h7F, 8'hFF, '0);
		send_op(OP_READ, 7'h35, '0, '0);
		for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
			send_op(3'(op), 7'($urandom_range(0, 127)), 8'hFF, 40'hFF_FFFF_FFFF);
		// reset ignores the address and restores the power-on image
		send_op(OP_RESET, 7'h7F, '0, '0);
		send_op(OP_READ, DEV_ADDR, '0, '0);
	endtask

	// status bits and readings across the configuration extremes
	task automatic test_config_settings();
		apply_setting(1'b0, 1'b0, 16'd0, 16'd0);
		read_derived();
		apply_setting(1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
		read_derived();
		// one below and at the saturation points
		apply_setting(1'b1, 1'b0, 16'd4505, 16'd6963);
		read_derived();
		apply_setting(1'b0, 1'b1, 16'd4506, 16'd6964);
		read_derived();
		// indexes past the last register change nothing
		wait_idle();
		write_config(CFG_OUT_OF_RANGE, 16'hFFFF);
		write_config(CFG_TOP_INDEX, 16'h0000);
		read_derived();
		apply_setting(1'b1, 1'b1, 16'($urandom), 16'($urandom));
		// reset op keeps the configuration and re-derives from it
		send_op(OP_RESET, DEV_ADDR, '0, '0);
		read_derived();
		apply_setting(1'b1, 1'b1, BAT_MV_RESET, BUS_MV_RESET);
		read_derived();
	endtask

	function automatic logic [7:0] pick_pointer();
		case ($urandom_range(0, 4))
			0:       return 8'($urandom_range(8'h3C, 8'h52));	// interrupt window
			1:       return 8'($urandom_range(8'h54, 8'h86));	// read-only edge
			2:       return 8'($urandom_range(8'hF8, 8'hFF));	// wrap
			3:       return 8'($urandom_range(8'h00, 8'h06));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_cfg_value();
		case ($urandom_range(0, 3))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly served bus traffic with random content, some noise
	task automatic test_random_traffic();
		int          r;
		logic [6:0]  dev;
		logic [39:0] flags;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i > 0 && i % 125 == 0) begin
				wait_idle();
				if ($urandom_range(0, 9) == 0)
					write_config(8'($urandom_range(4, 255)), 16'($urandom));
				else
					write_config(8'($urandom_range(0, 3)), pick_cfg_value());
			end
			quiet_stretch = (i >= 400 && i < 600);
			dev   = ($urandom_range(0, 99) < 92) ? DEV_ADDR : 7'($urandom_range(0, 127));
			flags = 40'({$urandom, $urandom});
			if ($urandom_range(0, 1) == 0)
				flags = flags & 40'({$urandom, $urandom}) & 40'({$urandom, $urandom});
			r = $urandom_range(0, 99);
			if (r < 14)
				send_op(OP_SET_PTR, dev, pick_pointer(), flags);
			else if (r < 44)
				send_op(OP_WRITE, dev, 8'($urandom), flags);
			else if (r < 82)
				send_op(OP_READ, dev, 8'($urandom), flags);
			else if (r < 93)
				send_op(OP_IRQ, 7'($urandom_range(0, 127)), 8'($urandom), flags);
			else if (r < 96)
				send_op(OP_RESET, 7'($urandom_range(0, 127)), 8'($urandom), flags);
			else
				send_op(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), dev,
					8'($urandom), flags);
		end
		quiet_stretch = 1'b0;
	endtask

	initial begin
		img_bat_present = 1'b1;
		img_bus_present = 1'b1;
		img_bat_mv      = BAT_MV_RESET;
		img_bus_mv      = BUS_MV_RESET;
		restore_image();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_config_settings();
		test_random_traffic();

		wait_idle();
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
